### hdl/windowed_peak_moving_average_macros.svh
// assertion macros used by the checker file
`ifndef WINDOWED_PEAK_MOVING_AVERAGE_MACROS_SVH
`define WINDOWED_PEAK_MOVING_AVERAGE_MACROS_SVH

// checked only while out of reset
`define WPMA_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define WPMA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### hdl/wpma_pkg.sv
// shared widths and constants of the windowed peak moving average
package wpma_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int TICKS_W   = 8;
	localparam int PERIOD_W  = 16;
	localparam int AVG_W     = 23;
	localparam int ELAPSED_W = 17;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = {ELAPSED_W{1'b1}};
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd1000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [TICKS_W-1:0]         ticks_t;
	typedef logic [PERIOD_W-1:0]        period_t;
	typedef logic [AVG_W-1:0]           avg_t;
	typedef logic [ELAPSED_W-1:0]       elapsed_t;

endpackage

### hdl/wpma_window.sv
// sample ring, running window sum, peak hold and period timer
module wpma_window import wpma_pkg::*; #(
	parameter int WINDOW = 16,
	parameter int PEAK_W = 27
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              item_ready,
	input  sample_t           sample,
	input  ticks_t            ticks_since_last,
	input  logic              cfg_we,
	input  period_t           cfg_wdata,
	output logic              emit_valid,
	output logic [PEAK_W-1:0] emit_peak
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = PEAK_W + 1;

	sample_t                  ring [WINDOW];
	sample_t                  oldest_q;
	logic                     wrapped_q;
	logic [PTR_W-1:0]         ptr_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [PEAK_W-1:0]        peak_q;
	elapsed_t                 elapsed_q;
	period_t                  period_q;

	logic                     accept;
	logic [ELAPSED_W:0]       elapsed_add;
	elapsed_t                 elapsed_nx;
	sample_t                  oldest;
	logic signed [SUM_W-1:0]  sum_nx;
	logic [PEAK_W-1:0]        peak_nx;
	logic                     raise;
	logic                     emit;
	logic                     ptr_last;
	logic [PTR_W-1:0]         ptr_nx;

	assign accept = in_valid && item_ready;

	always_comb begin
		elapsed_add = {1'b0, elapsed_q} + {{(ELAPSED_W + 1 - TICKS_W){1'b0}}, ticks_since_last};
		elapsed_nx  = elapsed_add[ELAPSED_W] ? ELAPSED_MAX : elapsed_add[ELAPSED_W-1:0];
		oldest      = wrapped_q ? oldest_q : '0;
		sum_nx      = sum_q - SUM_W'(oldest) + SUM_W'(sample);
		raise       = !sum_nx[SUM_W-1] && (sum_nx[PEAK_W-1:0] > peak_q);
		peak_nx     = raise ? sum_nx[PEAK_W-1:0] : peak_q;
		emit        = elapsed_nx >= {{(ELAPSED_W - PERIOD_W){1'b0}}, period_q};
		ptr_last    = ptr_q == PTR_W'(WINDOW - 1);
		ptr_nx      = ptr_last ? '0 : ptr_q + 1'b1;
	end

	assign emit_valid = accept && emit;
	assign emit_peak  = peak_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrapped_q <= 1'b0;
			ptr_q     <= '0;
			sum_q     <= '0;
			peak_q    <= '0;
			elapsed_q <= '0;
		end else if (accept) begin
			sum_q     <= sum_nx;
			ptr_q     <= ptr_nx;
			peak_q    <= emit ? '0 : peak_nx;
			elapsed_q <= emit ? '0 : elapsed_nx;
			if (ptr_last) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// ring slots fill in order, so entries past the fill point read as zero via wrapped_q
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[ptr_q] <= sample;
			oldest_q    <= (ptr_nx == ptr_q) ? sample : ring[ptr_nx];
		end
	end

endmodule

### hdl/wpma_divide.sv
// peak staging, divide by window and output register
module wpma_divide import wpma_pkg::*; #(
	parameter int WINDOW = 16,
	parameter int PEAK_W = 27
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit_valid,
	input  logic [PEAK_W-1:0] emit_peak,
	output logic              emit_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output avg_t              peak_average
);

	localparam int  SHIFT_L = $clog2(WINDOW);
	localparam bit  POW2    = (WINDOW & (WINDOW - 1)) == 0;
	localparam int  RECIP_W = PEAK_W + 1;
	localparam int  PROD_W  = PEAK_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << (PEAK_W + SHIFT_L)) / WINDOW) + 64'd1);

	logic              valid_s1;
	logic [PEAK_W-1:0] peak_s1;
	logic              out_valid_q;
	avg_t              avg_q;
	logic              adv_s1;
	avg_t              quot;

	generate
		if (POW2) begin : g_shift
			assign quot = peak_s1[PEAK_W-1:SHIFT_L];
		end else begin : g_recip
			logic [PROD_W-1:0] prod;
			assign prod = PROD_W'(peak_s1) * PROD_W'(RECIP);
			assign quot = prod[PEAK_W + SHIFT_L +: AVG_W];
		end
	endgenerate

	assign adv_s1     = valid_s1 && (!out_valid_q || out_ready);
	assign emit_ready = !valid_s1 || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit_valid) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			peak_s1 <= emit_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			avg_q <= quot;
		end
	end

	assign out_valid    = out_valid_q;
	assign peak_average = avg_q;

endmodule

### hdl/windowed_peak_moving_average.sv
// top level of the windowed peak moving average detector
// Takes one load-cell sample per clock cycle with the milliseconds since the
// previous one, keeps the sum of the last WINDOW samples (unfilled slots count
// as zero) and holds the largest non-negative sum of the current period. The
// elapsed counter saturates at 131071; when it reaches period_ms after adding
// the ticks, one peak_average (peak sum divided by WINDOW, truncated) goes out
// and the peak and the counter clear. The window update loads the staging
// register at the edge of the transfer that closes the period, and the divide
// by WINDOW then loads the output register once that register is empty or
// being read. Input stalls only while one result waits in the output register
// and another in the staging register. The sample ring is a WINDOW-entry
// register file read one slot ahead, so there is no clearing pass after reset.
// period_ms resets to 1000; the user must write it through cfg_we only while
// no transfer is in flight, and the block does not enforce this.
module windowed_peak_moving_average import wpma_pkg::*; #(
	parameter int WINDOW = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t sample,
	input  ticks_t  ticks_since_last,
	output logic    out_valid,
	input  logic    out_ready,
	output avg_t    peak_average,
	input  logic    cfg_we,
	input  period_t cfg_wdata
);

	localparam int PEAK_W = SAMPLE_W - 1 + $clog2(WINDOW);

	logic              emit_valid;
	logic [PEAK_W-1:0] emit_peak;
	logic              emit_ready;

	assign in_ready = emit_ready;

	wpma_window #(
		.WINDOW (WINDOW),
		.PEAK_W (PEAK_W)
	) u_window (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.item_ready       (emit_ready),
		.sample           (sample),
		.ticks_since_last (ticks_since_last),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.emit_valid       (emit_valid),
		.emit_peak        (emit_peak)
	);

	wpma_divide #(
		.WINDOW (WINDOW),
		.PEAK_W (PEAK_W)
	) u_divide (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit_valid   (emit_valid),
		.emit_peak    (emit_peak),
		.emit_ready   (emit_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.peak_average (peak_average)
	);

endmodule

### hdl/wpma_checker.sv
// port-level checks of the windowed peak moving average, bound to the top level
`include "windowed_peak_moving_average_macros.svh"

module wpma_checker import wpma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input avg_t peak_average
);

	// no result while in reset
	`WPMA_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !out_valid, "result shown during reset")

	// an empty output side never blocks input
	`WPMA_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled with no result waiting")

	// a new result follows an earlier input transfer
	`WPMA_ASSERT(a_result_latency, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without matching transfer")

	// a stalled result holds
	`WPMA_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(peak_average), "stalled result changed")

endmodule

bind windowed_peak_moving_average wpma_checker u_wpma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.peak_average (peak_average)
);

### sim/tb_windowed_peak_moving_average.sv
// testbench for windowed_peak_moving_average: directed table, then random sample runs checked against a peak-hold model
module tb_windowed_peak_moving_average;
	import wpma_pkg::*;

	localparam int WINDOW = 16;
	localparam int HALF_PERIOD = 10;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 64;
	localparam int TIMEOUT_UNITS = 4_000_000;
	localparam int NUM_DIRECTED = 17;
	localparam int NUM_PHASES = 6;
	localparam int QUIET_PHASE = 3;

	typedef enum logic [1:0] {RUN_ANY, RUN_TOP, RUN_BOTTOM, RUN_NEAR_ZERO} sample_run_e;

	typedef struct packed {
		period_t period;
		sample_t smp;
		ticks_t  tck;
		logic    typed;
		avg_t    want;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{16'd1000,  24'h7FFFFF, 8'd0,   1'b0, 23'd0},
		'{16'd1000,  24'h800000, 8'd255, 1'b0, 23'd0},
		'{16'd1000,  24'h000000, 8'd255, 1'b0, 23'd0},
		'{16'd1000,  24'h000000, 8'd255, 1'b0, 23'd0},
		'{16'd1000,  24'h000000, 8'd235, 1'b1, 23'd524287},
		'{16'd0,     24'h000000, 8'd0,   1'b1, 23'd0},
		'{16'd0,     24'h800000, 8'd0,   1'b1, 23'd0},
		'{16'd0,     24'h7FFFFF, 8'd0,   1'b1, 23'd0},
		'{16'd0,     24'h555555, 8'h55,  1'b0, 23'd0},
		'{16'd0,     24'hAAAAAA, 8'hAA,  1'b0, 23'd0},
		'{16'd1,     24'h123456, 8'd0,   1'b0, 23'd0},
		'{16'd1,     24'h7FFFFF, 8'd1,   1'b0, 23'd0},
		'{16'd255,   24'h7FFFFF, 8'd255, 1'b0, 23'd0},
		'{16'd255,   24'h7FFFFF, 8'd254, 1'b0, 23'd0},
		'{16'd255,   24'h7FFFFF, 8'd1,   1'b0, 23'd0},
		'{16'hFFFF,  24'h800000, 8'd255, 1'b0, 23'd0},
		'{16'hFFFF,  24'h7FFFFF, 8'h80,  1'b0, 23'd0}
	};

	localparam period_t PHASE_PERIOD [NUM_PHASES] = '{16'd0, 16'hFFFF, 16'd3, 16'd1000,
		16'd128, 16'd1};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 540, 150, 200, 200, 110};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	sample_t sample;
	ticks_t  ticks_since_last;
	logic    out_valid;
	logic    out_ready;
	avg_t    peak_average;
	logic    cfg_we;
	period_t cfg_wdata;

	sample_t     window_ring [WINDOW];
	int unsigned window_slot;
	int          window_total;
	int          peak_total;
	int unsigned elapsed_count;
	period_t     period_reg;
	avg_t        pending_averages [$];

	int          mismatches;
	bit          gaps_on;
	int          hold_requests;
	int          holds_done;
	bit          row_typed;
	avg_t        row_want;
	sample_run_e run_mode;
	int          run_left;

	windowed_peak_moving_average #(.WINDOW(WINDOW)) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample           (sample),
		.ticks_since_last (ticks_since_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.peak_average     (peak_average),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic advance_peak_model(input sample_t s, input ticks_t t);
		int unsigned sum_ticks;
		bit closes;
		sum_ticks = elapsed_count + t;
		elapsed_count = (sum_ticks > ELAPSED_MAX) ? ELAPSED_MAX : sum_ticks;
		window_total = window_total - int'(window_ring[window_slot]) + int'(s);
		window_ring[window_slot] = s;
		window_slot = (window_slot + 1) % WINDOW;
		if (window_total > peak_total)
			peak_total = window_total;
		closes = elapsed_count >= period_reg;
		if (row_typed)
			pending_averages.push_back(row_want);
		else if (closes)
			pending_averages.push_back(avg_t'(peak_total / WINDOW));
		if (closes) begin
			peak_total = 0;
			elapsed_count = 0;
		end
	endtask

	task automatic offer_item(input sample_t s, input ticks_t t, input bit typed, input avg_t want);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_want = want;
		in_valid <= 1'b1;
		sample <= s;
		ticks_since_last <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_period(input period_t p);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		period_reg = p;
	endtask

	task automatic pick_sample(output sample_t s);
		if (run_left == 0) begin
			run_mode = sample_run_e'($urandom_range(0, 3));
			run_left = $urandom_range(1, 40);
		end
		run_left--;
		case (run_mode)
			RUN_TOP:       s = sample_t'(24'h7FFFFF - $urandom_range(0, 3));
			RUN_BOTTOM:    s = sample_t'(24'h800000 + $urandom_range(0, 3));
			RUN_NEAR_ZERO: s = sample_t'($urandom_range(0, 64) - 32);
			default:       s = sample_t'($urandom());
		endcase
	endtask

	task automatic pick_ticks(input bit long_period, output ticks_t t);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (long_period && roll < 85)
			t = '1;
		else if (roll < 10)
			t = '0;
		else if (roll < 20)
			t = '1;
		else
			t = ticks_t'($urandom());
	endtask

	// prediction on each input transfer, then check of each output transfer
	always @(posedge clk) begin : result_check
		avg_t oldest;
		if (arst_n) begin
			if (in_valid && in_ready)
				advance_peak_model(sample, ticks_since_last);
			if (out_valid && out_ready) begin
				if (pending_averages.size() == 0) begin
					$display("%0t: unexpected peak_average, expected none, actual %0d",
						$time, peak_average);
					mismatches++;
				end else begin
					oldest = pending_averages.pop_front();
					if (peak_average !== oldest) begin
						$display("%0t: peak_average mismatch, expected %0d, actual %0d",
							$time, oldest, peak_average);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else begin
				out_ready <= !gaps_on || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		sample_t s;
		ticks_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		ticks_since_last = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		gaps_on = 1'b1;
		hold_requests = 0;
		holds_done = 0;
		row_typed = 1'b0;
		row_want = '0;
		run_mode = RUN_ANY;
		run_left = 0;
		mismatches = 0;
		for (int i = 0; i < WINDOW; i++)
			window_ring[i] = '0;
		window_slot = 0;
		window_total = 0;
		peak_total = 0;
		elapsed_count = 0;
		period_reg = PERIOD_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].period != period_reg)
				write_period(DIRECTED_ROWS[i].period);
			offer_item(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].tck, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_period(PHASE_PERIOD[ph]);
			gaps_on = (ph != QUIET_PHASE);
			for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
				// receiver backs off while items keep coming
				if (n == 20 && (ph == 0 || ph == 4))
					hold_requests++;
				pick_sample(s);
				pick_ticks(PHASE_PERIOD[ph] == '1, t);
				offer_item(s, t, 1'b0, '0);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
